/* rtl/disc_min_filter_top_defines.svh */
// ----------------------------------------------------------------------------
// disc_min_filter_top_defines.svh - assertion macros
// Concurrent assertion shorthands used by the disc minimum filter RTL.
// ----------------------------------------------------------------------------
`ifndef DISC_MIN_FILTER_TOP_DEFINES_SVH
`define DISC_MIN_FILTER_TOP_DEFINES_SVH

// clocked assertion, disabled while reset is asserted
`define DMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define DMF_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/dmf_pkg.sv */
// ----------------------------------------------------------------------------
// dmf_pkg - disc minimum filter package
// Widths, codes, cell control struct and the small integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

package dmf_pkg;

	localparam int MAX_RADIUS = 16;
	localparam int MAX_WIDTH  = 2048;
	localparam int FULL_SCALE = 4096;

	// field widths
	localparam int PIX_W  = 13;
	localparam int HINT_W = 2;
	localparam int R2_W   = 9;
	localparam int WID_W  = 12;
	localparam int IDX_W  = 1;

	// derived sizes
	localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int SLOT_W    = $clog2(LINE_ROWS);
	localparam int ROW_W     = $clog2(LINE_ROWS);
	localparam int CNT_W     = $clog2(LINE_ROWS + 1);
	localparam int ADDR_W    = SLOT_W + COL_W;
	localparam int RAM_DEPTH = LINE_ROWS * MAX_WIDTH;

	localparam logic [PIX_W-1:0] ALPHA_FULL = PIX_W'(FULL_SCALE);
	localparam logic [R2_W-1:0]  R2_MAX     = R2_W'(MAX_RADIUS * MAX_RADIUS);

	typedef logic [LINE_ROWS-1:0][PIX_W-1:0] col_vec_t;

	// reserved code behaves as compute
	typedef enum logic [HINT_W-1:0] {
		HINT_COMPUTE = 2'd0,
		HINT_ZERO    = 2'd1,
		HINT_FULL    = 2'd2,
		HINT_RSVD    = 2'd3
	} hint_t;

	typedef enum logic [IDX_W-1:0] {
		REG_RADIUS_SQ   = 1'b0,
		REG_IMAGE_WIDTH = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROTATE,
		ST_REDUCE,
		ST_OUT
	} state_t;

	// per-cell controls
	typedef struct packed {
		logic hshift;   // take the column of the left neighbor
		logic load;     // shift a fresh sample into the column
		logic rotate;   // rotate the column by one row
		logic take;     // fold the head sample into the accumulator
		logic clear;    // accumulator to full scale
		logic reduce;   // fold the right neighbor's accumulator
	} cell_ctl_t;

	// floor(sqrt(v)) for v up to MAX_RADIUS squared
	function automatic logic [RAD_W-1:0] isqrt_small(input logic [R2_W-1:0] v);
		logic [RAD_W-1:0] s;
		s = '0;
		for (int k = 1; k <= MAX_RADIUS; k++) begin
			if (k * k <= int'(v))
				s = RAD_W'(k);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

/* rtl/dmf_stream_if.sv */
// ----------------------------------------------------------------------------
// dmf_stream_if - sample and result channels
// Valid/ready channels carrying source samples and filter results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dmf_in_if;
	logic                       valid;
	logic                       ready;
	logic [dmf_pkg::PIX_W-1:0]  pixel_value;
	logic [dmf_pkg::HINT_W-1:0] hint;
	logic                       frame_start;

	modport source (output valid, pixel_value, hint, frame_start, input ready);
	modport sink   (input valid, pixel_value, hint, frame_start, output ready);
endinterface

interface dmf_out_if;
	logic                      valid;
	logic                      ready;
	logic [dmf_pkg::PIX_W-1:0] min_value;
	logic                      row_end;

	modport source (output valid, min_value, row_end, input ready);
	modport sink   (input valid, min_value, row_end, output ready);
endinterface

`default_nettype wire

/* rtl/dmf_ram.sv */
// ----------------------------------------------------------------------------
// dmf_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* rtl/dmf_cell.sv */
// ----------------------------------------------------------------------------
// dmf_cell - one window column of the disc filter
// Holds one source column of the window and a running minimum; passes the
// column right between items and the minimum left during the reduction.
// ----------------------------------------------------------------------------
`default_nettype none

module dmf_cell (
	input  wire logic                      clk,
	input  wire dmf_pkg::cell_ctl_t        ctl,
	input  wire dmf_pkg::col_vec_t         vec_in,
	input  wire logic [dmf_pkg::PIX_W-1:0] load_word,
	input  wire logic [dmf_pkg::PIX_W-1:0] acc_in,
	output      dmf_pkg::col_vec_t         vec_out,
	output      logic [dmf_pkg::PIX_W-1:0] acc_out
);
	import dmf_pkg::*;

	col_vec_t         vec_q;
	logic [PIX_W-1:0] acc_q;
	logic [PIX_W-1:0] tail;

	// word entering the top of the column on a shift
	assign tail = ctl.load ? load_word : vec_q[0];

	// column storage
	always_ff @(posedge clk) begin
		if (ctl.hshift) begin
			vec_q <= vec_in;
		end else if (ctl.load || ctl.rotate) begin
			for (int i = 0; i < LINE_ROWS - 1; i++)
				vec_q[i] <= vec_q[i + 1];
			vec_q[LINE_ROWS-1] <= tail;
		end
	end

	// running minimum
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= ALPHA_FULL;
		end else if (ctl.rotate && ctl.take) begin
			if (vec_q[0] < acc_q)
				acc_q <= vec_q[0];
		end else if (ctl.reduce) begin
			if (acc_in < acc_q)
				acc_q <= acc_in;
		end
	end

	assign vec_out = vec_q;
	assign acc_out = acc_q;

endmodule

`default_nettype wire

/* rtl/disc_min_filter_top.sv */
// ----------------------------------------------------------------------------
// disc_min_filter_top - grayscale erosion with a disc
// Line store, window cell row and item sequencer.
// ----------------------------------------------------------------------------
// Samples arrive in raster order and are kept in a line store RAM holding
// 2*MAX_RADIUS+1 rows. A row of 2*MAX_RADIUS+1 cells holds the window
// columns. Each sample is transferred and then has its column pulled out of
// the single RAM read port. A sample that computes a disc minimum then
// rotates the columns through the cells, passes the partial minima down the
// cell row and loads the output register. Forced results skip the rotation
// and reduction. No result is produced until 2R+1 rows and 2R+1 columns are
// present. A register write restarts the frame; the line store needs no
// clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module disc_min_filter_top (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	dmf_in_if.sink                         sample,
	dmf_out_if.source                      result,
	input  wire logic                      wr_en,
	input  wire logic [dmf_pkg::IDX_W-1:0] wr_index,
	input  wire logic [dmf_pkg::WID_W-1:0] wr_data
);
	import dmf_pkg::*;

	`include "disc_min_filter_top_defines.svh"

	state_t state_q, state_nx;

	// configuration
	logic [R2_W-1:0]  r2_q;
	logic [RAD_W-1:0] r_q;
	logic [WID_W-1:0] width_q;
	logic [R2_W-1:0]  r2_wr;

	// frame position
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] slot_q;

	// item context
	logic [COL_W-1:0]  icol_q;
	logic [SLOT_W-1:0] rslot_q;
	logic              emit_q;
	logic              last_q;
	logic [HINT_W-1:0] hint_q;
	logic [CNT_W-1:0]  cnt_q;

	// output register
	logic             ov_q;
	logic [PIX_W-1:0] omin_q;
	logic             oend_q;

	logic              accept;
	logic [WID_W-1:0]  w_eff;
	logic [ROW_W-1:0]  two_r;
	logic [ROW_W-1:0]  rows;
	logic [COL_W-1:0]  col0, colx;
	logic [ROW_W-1:0]  row0;
	logic [SLOT_W-1:0] slot0, slotx;
	logic [PIX_W-1:0]  pix_c;
	logic              emit_c, last_c;
	logic [PIX_W-1:0]  rdata;
	logic              forced;
	logic              out_free;
	logic [PIX_W-1:0]  res_val;

	// FSM outputs
	logic st_load, st_rotate, st_reduce, st_out;

	// rotation mask
	logic                 b_valid;
	logic [ROW_W-1:0]     roff;
	logic [2*ROW_W-1:0]   dsq;
	logic [R2_W-1:0]      hv;
	logic [RAD_W-1:0]     hw;
	logic [ROW_W-1:0]     jd [LINE_ROWS];
	logic [LINE_ROWS-1:0] take;

	cell_ctl_t        ctl [LINE_ROWS];
	col_vec_t         vec_w [LINE_ROWS];
	logic [PIX_W-1:0] acc_w [LINE_ROWS];

	// effective geometry
	assign w_eff = (width_q == '0) ? WID_W'(1) :
	               (width_q > WID_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : width_q;
	assign two_r = ROW_W'(r_q) << 1;
	assign rows  = two_r + ROW_W'(1);
	assign r2_wr = (wr_data[R2_W-1:0] > R2_MAX) ? R2_MAX : wr_data[R2_W-1:0];

	// position of the incoming sample
	assign col0   = sample.frame_start ? '0 : col_q;
	assign row0   = sample.frame_start ? '0 : row_q;
	assign slot0  = sample.frame_start ? '0 : slot_q;
	assign colx   = (WID_W'(col0) >= w_eff) ? '0 : col0;
	assign slotx  = (slot0 >= rows) ? '0 : slot0;
	assign pix_c  = (sample.pixel_value > ALPHA_FULL) ? ALPHA_FULL : sample.pixel_value;
	assign emit_c = (row0 >= two_r) && (colx >= COL_W'(two_r));
	assign last_c = (WID_W'(colx) + WID_W'(1)) == w_eff;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);

	// line store
	dmf_ram #(
		.WIDTH (PIX_W),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (accept),
		.waddr ({slotx, colx}),
		.wdata (pix_c),
		.raddr ({rslot_q, icol_q}),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				if (cnt_q == CNT_W'(LINE_ROWS)) begin
					if (!emit_q)
						state_nx = ST_IDLE;
					else if (forced)
						state_nx = ST_OUT;
					else
						state_nx = ST_ROTATE;
				end
			end
			ST_ROTATE: begin
				if (cnt_q == CNT_W'(LINE_ROWS - 1))
					state_nx = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (cnt_q == CNT_W'(LINE_ROWS - 2))
					state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (out_free)
					state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	// state decode
	always_comb begin
		st_load   = 1'b0;
		st_rotate = 1'b0;
		st_reduce = 1'b0;
		st_out    = 1'b0;
		case (state_q)
			ST_LOAD:   st_load   = 1'b1;
			ST_ROTATE: st_rotate = 1'b1;
			ST_REDUCE: st_reduce = 1'b1;
			ST_OUT:    st_out    = 1'b1;
			default: ;
		endcase
	end

	assign forced   = (hint_q == HINT_ZERO) || (hint_q == HINT_FULL);
	assign out_free = !ov_q || result.ready;
	assign res_val  = (hint_q == HINT_ZERO) ? '0 :
	                  (hint_q == HINT_FULL) ? ALPHA_FULL : acc_w[0];

	// disc row half width for the row under rotation
	assign b_valid = st_rotate && (ROW_W'(cnt_q) < rows);
	assign roff    = (ROW_W'(cnt_q) > ROW_W'(r_q)) ? ROW_W'(cnt_q) - ROW_W'(r_q) :
	                 ROW_W'(r_q) - ROW_W'(cnt_q);
	assign dsq     = roff * roff;
	assign hv      = ((2*ROW_W)'(r2_q) >= dsq) ? r2_q - R2_W'(dsq) : '0;
	assign hw      = isqrt_small(hv);

	// per-cell mask and controls
	always_comb begin
		for (int j = 0; j < LINE_ROWS; j++) begin
			jd[j] = (ROW_W'(j) > ROW_W'(r_q)) ? ROW_W'(j) - ROW_W'(r_q) :
			        ROW_W'(r_q) - ROW_W'(j);
			take[j] = b_valid && (jd[j] <= ROW_W'(hw));
			ctl[j].hshift = accept;
			ctl[j].load   = (j == 0) && st_load && (cnt_q != '0);
			ctl[j].rotate = st_rotate;
			ctl[j].take   = take[j];
			ctl[j].clear  = accept;
			ctl[j].reduce = st_reduce;
		end
	end

	// cell row
	for (genvar j = 0; j < LINE_ROWS; j++) begin : g_cell
		col_vec_t         nb_vec;
		logic [PIX_W-1:0] nb_acc;
		if (j == 0) begin : g_first
			assign nb_vec = '0;
		end else begin : g_inner
			assign nb_vec = vec_w[j-1];
		end
		if (j == LINE_ROWS - 1) begin : g_last
			assign nb_acc = ALPHA_FULL;
		end else begin : g_body
			assign nb_acc = acc_w[j+1];
		end
		dmf_cell u_cell (
			.clk       (clk),
			.ctl       (ctl[j]),
			.vec_in    (nb_vec),
			.load_word (rdata),
			.acc_in    (nb_acc),
			.vec_out   (vec_w[j]),
			.acc_out   (acc_w[j])
		);
	end

	// state and sequencing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_nx != state_q)
				cnt_q <= '0;
			else if (st_load || st_rotate || st_reduce)
				cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// configuration and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r2_q    <= R2_W'(1);
			r_q     <= RAD_W'(1);
			width_q <= WID_W'(MAX_WIDTH);
			col_q   <= '0;
			row_q   <= '0;
			slot_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_RADIUS_SQ: begin
					r2_q <= r2_wr;
					r_q  <= isqrt_small(r2_wr);
				end
				REG_IMAGE_WIDTH: width_q <= wr_data;
				default: ;
			endcase
			col_q  <= '0;
			row_q  <= '0;
			slot_q <= '0;
		end else if (accept) begin
			if (last_c) begin
				col_q  <= '0;
				row_q  <= (row0 < two_r) ? row0 + ROW_W'(1) : row0;
				slot_q <= (slotx + SLOT_W'(1) == rows) ? '0 : slotx + SLOT_W'(1);
			end else begin
				col_q  <= colx + COL_W'(1);
				row_q  <= row0;
				slot_q <= slotx;
			end
		end
	end

	// item context and read slot walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q <= 1'b0;
		end else if (accept) begin
			emit_q <= emit_c;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			icol_q  <= colx;
			rslot_q <= slotx;
			last_q  <= last_c;
			hint_q  <= sample.hint;
		end else if (st_load && cnt_q < CNT_W'(LINE_ROWS)) begin
			rslot_q <= (rslot_q == '0) ? rows - SLOT_W'(1) : rslot_q - SLOT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (st_out && out_free) begin
			ov_q <= 1'b1;
		end else if (result.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_out && out_free) begin
			omin_q <= res_val;
			oend_q <= last_q;
		end
	end

	assign result.valid     = ov_q;
	assign result.min_value = omin_q;
	assign result.row_end   = oend_q;

	// checks
	`DMF_ASSERT(a_load_bound, st_load |-> cnt_q <= CNT_W'(LINE_ROWS), "load count overrun")
	`DMF_ASSERT(a_out_emit, st_out |-> emit_q, "result for a sample with no window")
	`DMF_ASSERT(a_accept_load, accept |=> st_load, "transfer not followed by column load")
	`DMF_ASSERT(a_row_sat, row_q <= two_r, "row count above 2R")

endmodule

`default_nettype wire
